// ===== design/pcdf_pkg.sv =====
// Package for the plasma cavity depletion factor block.
// Shared widths, register indexes, sine coefficients and latency helpers.
// No dependencies.
`timescale 1ns / 1ps

package pcdf_pkg;

    // default fixed point formats
    localparam int FRAC_BITS_DEF = 16;
    localparam int TRIG_BITS_DEF = 16;

    // angle numerator and span widths seen by the trig unit
    localparam int NUM_W  = 25;
    localparam int SPAN_W = 24;

    // configuration port
    localparam int CFG_W      = 24;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_ILAT_CENTER    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ILAT_HALFWIDTH = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MLT_CENTER     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MLT_HALFWIDTH  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TOP_HEIGHT     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BOTTOM_HEIGHT  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_DEPTH_SCALE    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_CAVITY_ENABLED = 3'd7;

    // one day in hours Q.16, and 1.0 in Q1.16
    localparam int DAY_Q16 = 24 * 65536;
    localparam int ONE_Q16 = 65536;

    // odd polynomial for sine on the quarter wave, Q30, highest order first
    localparam logic [31:0] SIN_COEF [6] = '{
        32'd3864, 32'd172272, 32'd5026995,
        32'd85569306, 32'd693598668, 32'd1686629713
    };

    // sine section: phase/x, x squared, five Horner steps, final product
    localparam int SIN_STAGES = 8;

    // register stages of the trig unit: one per quotient bit, then sine
    function automatic int trig_latency(input int trig_bits);
        return NUM_W + trig_bits + 1 + SIN_STAGES;
    endfunction

endpackage

// ===== design/plasma_cavity_depletion_factor.sv =====
// Top level of the plasma cavity depletion factor block.
// Window tests, four trig units and the blend pipeline; uses pcdf_pkg, pcdf_trig.
`timescale 1ns / 1ps

// Usage:
//   Input channel s_valid/s_ready carries one sample point per request:
//   s_altitude (signed meters), s_inv_latitude and s_local_time (Q.16).
//   Output channel m_valid/m_ready returns m_density_factor (Q1.16) and
//   m_inside_res for each point, in order.
//   Configuration is a plain write port: cfg_we, cfg_addr, cfg_wdata; write
//   only while no request is in flight.
//   Throughput: one request per cycle while the skid register is empty.
//   The pipeline depth comes from the angle dividers, which resolve one
//   quotient bit per register stage over NUM_W + TRIG_BITS + 1 stages,
//   followed by eight sine stages, two front stages, five blend stages and
//   the output register.
//   Reset (aresetn low, synchronous) empties the pipeline and loads the
//   register defaults; the cavity starts disabled.
//   When the receiver stalls, one finished result waits in the output
//   register and one more in a skid register; the pipeline then freezes and
//   s_ready drops until the skid register drains.
module plasma_cavity_depletion_factor import pcdf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int TRIG_BITS = TRIG_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [24:0]    s_altitude,
    input  logic [22:0]           s_inv_latitude,
    input  logic [20:0]           s_local_time,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [16:0]           m_density_factor,
    output logic                  m_inside_res,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    localparam int L = trig_latency(TRIG_BITS);
    localparam logic [FRAC_BITS:0] ONE_F = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [2*FRAC_BITS+1:0] HALF_P = (2*FRAC_BITS+2)'(1) << (FRAC_BITS - 1);
    localparam logic signed [23:0] DAY = 24'(DAY_Q16);
    localparam logic [16:0] ONE_OUT = 17'(ONE_Q16);

    function automatic logic [FRAC_BITS:0] fmul(input logic [FRAC_BITS:0] a,
                                                 input logic [FRAC_BITS:0] b);
        logic [2*FRAC_BITS+1:0] p;
        p = (2*FRAC_BITS+2)'(a) * (2*FRAC_BITS+2)'(b) + HALF_P;
        return p[2*FRAC_BITS:FRAC_BITS];
    endfunction

    // configuration registers
    logic [22:0] cfg_ilat_center_reg, cfg_ilat_halfwidth_reg;
    logic [20:0] cfg_mlt_center_reg, cfg_mlt_halfwidth_reg;
    logic [23:0] cfg_top_height_reg, cfg_bottom_height_reg;
    logic [16:0] cfg_depth_scale_reg;
    logic        cfg_cavity_enabled_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_ilat_center_reg    <= '0;
            cfg_ilat_halfwidth_reg <= 23'd65536;
            cfg_mlt_center_reg     <= '0;
            cfg_mlt_halfwidth_reg  <= 21'd65536;
            cfg_top_height_reg     <= '0;
            cfg_bottom_height_reg  <= 24'd1;
            cfg_depth_scale_reg    <= 17'd65536;
            cfg_cavity_enabled_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_ILAT_CENTER:    cfg_ilat_center_reg    <= cfg_wdata[22:0];
                REG_ILAT_HALFWIDTH: cfg_ilat_halfwidth_reg <= cfg_wdata[22:0];
                REG_MLT_CENTER:     cfg_mlt_center_reg     <= cfg_wdata[20:0];
                REG_MLT_HALFWIDTH:  cfg_mlt_halfwidth_reg  <= cfg_wdata[20:0];
                REG_TOP_HEIGHT:     cfg_top_height_reg     <= cfg_wdata;
                REG_BOTTOM_HEIGHT:  cfg_bottom_height_reg  <= cfg_wdata;
                REG_DEPTH_SCALE:    cfg_depth_scale_reg    <= cfg_wdata[16:0];
                REG_CAVITY_ENABLED: cfg_cavity_enabled_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // derive window edges, spans and scale from the registers
    logic signed [23:0] mmin_reg, mmax_reg;
    logic [23:0]        hgap_reg, aspan_reg;
    logic               b_le_a_reg;
    logic [FRAC_BITS:0] s_reg, oms_reg;

    logic [16:0]          ds_sat;
    logic [FRAC_BITS+17:0] s_wide;
    logic [FRAC_BITS:0]   s_val;

    always_comb begin
        ds_sat = (cfg_depth_scale_reg > ONE_OUT) ? ONE_OUT : cfg_depth_scale_reg;
        s_wide = (FRAC_BITS+18)'({ds_sat, {FRAC_BITS{1'b0}}}) + (FRAC_BITS+18)'(32768);
        s_val  = s_wide[FRAC_BITS+16:16];
    end

    always_ff @(posedge aclk) begin
        mmin_reg   <= signed'({3'b000, cfg_mlt_center_reg}) - signed'({3'b000, cfg_mlt_halfwidth_reg});
        mmax_reg   <= signed'({3'b000, cfg_mlt_center_reg}) + signed'({3'b000, cfg_mlt_halfwidth_reg});
        hgap_reg   <= cfg_top_height_reg - cfg_bottom_height_reg;
        b_le_a_reg <= cfg_top_height_reg <= cfg_bottom_height_reg;
        aspan_reg  <= (cfg_bottom_height_reg == '0) ? 24'd1 : cfg_bottom_height_reg;
        s_reg      <= s_val;
        oms_reg    <= ONE_F - s_val;
    end

    // pipeline enable: hold everything while the skid register is occupied
    logic en;
    logic skid_full_reg;
    assign en      = !skid_full_reg;
    assign s_ready = en;

    // stage 1: capture the request
    logic               v1_reg;
    logic signed [24:0] p1_alt_reg;
    logic [22:0]        p1_lat_reg;
    logic [20:0]        p1_mlt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_alt_reg <= s_altitude;
            p1_lat_reg <= s_inv_latitude;
            p1_mlt_reg <= s_local_time;
        end
    end

    // stage 2: window tests and angle operands
    logic signed [23:0] dlat, m_adj, dmlt;
    logic [23:0]        adlat, admlt;
    logic signed [25:0] alt_x, hdiff, habs;
    logic               lat_out, top_out, mlt_out, h_lt_a, inside_c;
    logic [NUM_W-1:0]   hnum_c, lnum_c, mnum_c;
    logic [SPAN_W-1:0]  hspan_c, lspan_c, mspan_c;

    always_comb begin
        dlat    = signed'({1'b0, p1_lat_reg}) - signed'({1'b0, cfg_ilat_center_reg});
        adlat   = dlat[23] ? 24'(-dlat) : 24'(dlat);
        lat_out = adlat > {1'b0, cfg_ilat_halfwidth_reg};

        alt_x   = {p1_alt_reg[24], p1_alt_reg};
        top_out = signed'({2'b00, cfg_top_height_reg}) < alt_x;

        // wrap local time by a day when the window crosses midnight
        m_adj = signed'({3'b000, p1_mlt_reg});
        if (mmin_reg < 0 && mmax_reg < m_adj) begin
            m_adj = m_adj - DAY;
        end
        if (mmax_reg > DAY && mmin_reg > m_adj) begin
            m_adj = m_adj + DAY;
        end
        mlt_out = (m_adj < mmin_reg) || (mmax_reg < m_adj);
        dmlt    = m_adj - signed'({3'b000, cfg_mlt_center_reg});
        admlt   = dmlt[23] ? 24'(-dmlt) : 24'(dmlt);

        inside_c = cfg_cavity_enabled_reg && !lat_out && !top_out && !mlt_out;

        // height profile: cosine below bottom, sine above it
        h_lt_a = alt_x < signed'({2'b00, cfg_bottom_height_reg});
        habs   = alt_x[25] ? -alt_x : alt_x;
        hdiff  = alt_x - signed'({2'b00, cfg_bottom_height_reg});
        if (h_lt_a) begin
            hnum_c  = habs[NUM_W-1:0];
            hspan_c = aspan_reg;
        end else if (b_le_a_reg) begin
            hnum_c  = '0;
            hspan_c = 24'd1;
        end else begin
            hnum_c  = hdiff[NUM_W-1:0];
            hspan_c = hgap_reg;
        end

        // zero half width gives angle zero
        if (cfg_ilat_halfwidth_reg == '0) begin
            lnum_c  = '0;
            lspan_c = 24'd1;
        end else begin
            lnum_c  = NUM_W'(adlat);
            lspan_c = {1'b0, cfg_ilat_halfwidth_reg};
        end
        if (cfg_mlt_halfwidth_reg == '0) begin
            mnum_c  = '0;
            mspan_c = 24'd1;
        end else begin
            mnum_c  = NUM_W'(admlt);
            mspan_c = {3'b000, cfg_mlt_halfwidth_reg};
        end
    end

    logic              v2_reg, p2_inside_reg, p2_hcos_reg;
    logic [NUM_W-1:0]  p2_hnum_reg, p2_lnum_reg, p2_mnum_reg;
    logic [SPAN_W-1:0] p2_hspan_reg, p2_lspan_reg, p2_mspan_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_inside_reg <= inside_c;
            p2_hcos_reg   <= h_lt_a;
            p2_hnum_reg   <= hnum_c;
            p2_hspan_reg  <= hspan_c;
            p2_lnum_reg   <= lnum_c;
            p2_lspan_reg  <= lspan_c;
            p2_mnum_reg   <= mnum_c;
            p2_mspan_reg  <= mspan_c;
        end
    end

    // trig units
    logic [FRAC_BITS:0] hf, sx, cy, sy;

    pcdf_trig #(.FRAC_BITS(FRAC_BITS), .TRIG_BITS(TRIG_BITS)) u_trig_h (
        .aclk(aclk), .en(en), .num(p2_hnum_reg), .span(p2_hspan_reg),
        .use_cos(p2_hcos_reg), .mag(hf)
    );
    pcdf_trig #(.FRAC_BITS(FRAC_BITS), .TRIG_BITS(TRIG_BITS)) u_trig_lat (
        .aclk(aclk), .en(en), .num(p2_lnum_reg), .span(p2_lspan_reg),
        .use_cos(1'b0), .mag(sx)
    );
    pcdf_trig #(.FRAC_BITS(FRAC_BITS), .TRIG_BITS(TRIG_BITS)) u_trig_mcos (
        .aclk(aclk), .en(en), .num(p2_mnum_reg), .span(p2_mspan_reg),
        .use_cos(1'b1), .mag(cy)
    );
    pcdf_trig #(.FRAC_BITS(FRAC_BITS), .TRIG_BITS(TRIG_BITS)) u_trig_msin (
        .aclk(aclk), .en(en), .num(p2_mnum_reg), .span(p2_mspan_reg),
        .use_cos(1'b0), .mag(sy)
    );

    // valid and inside flags alongside the trig units
    logic tv_reg [L];
    logic ti_reg [L];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < L; k++) begin
                tv_reg[k] <= 1'b0;
            end
        end else if (en) begin
            tv_reg[0] <= v2_reg;
            for (int k = 1; k < L; k++) begin
                tv_reg[k] <= tv_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ti_reg[0] <= p2_inside_reg;
            for (int k = 1; k < L; k++) begin
                ti_reg[k] <= ti_reg[k-1];
            end
        end
    end

    // blend stages
    logic               q1_v_reg, q2_v_reg, q3_v_reg, q4_v_reg, q5_v_reg;
    logic               q1_in_reg, q2_in_reg, q3_in_reg, q4_in_reg, q5_in_reg;
    logic [FRAC_BITS:0] q1_hf2_reg, q1_sx2_reg, q1_cy2_reg, q1_sy2_reg;
    logic [FRAC_BITS:0] q2_base_reg, q2_a_reg, q2_sy2_reg;
    logic [FRAC_BITS:0] q3_base_reg, q3_bowl_reg;
    logic [FRAC_BITS:0] q4_g_reg;
    logic [16:0]        q5_df_reg;

    logic [FRAC_BITS+1:0]  base_sum, bowl_sum, g_sum;
    logic [FRAC_BITS:0]    res_sq;
    logic [FRAC_BITS+17:0] fin_wide;
    logic [17:0]           fin_q16;

    always_comb begin
        base_sum = (FRAC_BITS+2)'(fmul(oms_reg, q1_hf2_reg)) + (FRAC_BITS+2)'(s_reg);
        bowl_sum = (FRAC_BITS+2)'(q2_a_reg) + (FRAC_BITS+2)'(q2_sy2_reg);
        g_sum    = (FRAC_BITS+2)'(fmul(ONE_F - q3_base_reg, q3_bowl_reg))
                 + (FRAC_BITS+2)'(q3_base_reg);
        res_sq   = fmul(q4_g_reg, q4_g_reg);
        fin_wide = (FRAC_BITS+18)'({res_sq, 16'h0000})
                 + ((FRAC_BITS+18)'(1) << (FRAC_BITS - 1));
        fin_q16  = fin_wide[FRAC_BITS+17:FRAC_BITS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q1_v_reg <= 1'b0;
            q2_v_reg <= 1'b0;
            q3_v_reg <= 1'b0;
            q4_v_reg <= 1'b0;
            q5_v_reg <= 1'b0;
        end else if (en) begin
            q1_v_reg <= tv_reg[L-1];
            q2_v_reg <= q1_v_reg;
            q3_v_reg <= q2_v_reg;
            q4_v_reg <= q3_v_reg;
            q5_v_reg <= q4_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q1_in_reg  <= ti_reg[L-1];
            q1_hf2_reg <= fmul(hf, hf);
            q1_sx2_reg <= fmul(sx, sx);
            q1_cy2_reg <= fmul(cy, cy);
            q1_sy2_reg <= fmul(sy, sy);

            q2_in_reg   <= q1_in_reg;
            q2_base_reg <= base_sum[FRAC_BITS:0];
            q2_a_reg    <= fmul(q1_sx2_reg, q1_cy2_reg);
            q2_sy2_reg  <= q1_sy2_reg;

            q3_in_reg   <= q2_in_reg;
            q3_base_reg <= q2_base_reg;
            q3_bowl_reg <= (bowl_sum > (FRAC_BITS+2)'(ONE_F)) ? ONE_F : bowl_sum[FRAC_BITS:0];

            q4_in_reg <= q3_in_reg;
            q4_g_reg  <= g_sum[FRAC_BITS:0];

            // points outside the cavity leave the density untouched
            q5_in_reg <= q4_in_reg;
            if (!q4_in_reg || fin_q16 > 18'(ONE_OUT)) begin
                q5_df_reg <= ONE_OUT;
            end else begin
                q5_df_reg <= fin_q16[16:0];
            end
        end
    end

    // output register with skid stage
    logic        m_valid_reg, m_in_reg, skid_in_reg;
    logic [16:0] m_df_reg, skid_df_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end else begin
            if (skid_full_reg) begin
                if (m_ready) begin
                    m_df_reg      <= skid_df_reg;
                    m_in_reg      <= skid_in_reg;
                    skid_full_reg <= 1'b0;
                end
            end else if (q5_v_reg) begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_reg <= 1'b1;
                    m_df_reg    <= q5_df_reg;
                    m_in_reg    <= q5_in_reg;
                end else begin
                    skid_full_reg <= 1'b1;
                    skid_df_reg   <= q5_df_reg;
                    skid_in_reg   <= q5_in_reg;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_density_factor = m_df_reg;
    assign m_inside_res     = m_in_reg;

`ifndef NO_ASSERTIONS
    // a parked result always sits behind a shown one
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> m_valid_reg)
        else $error("skid register full while output empty");

    // skid stays occupied and input stays blocked while the receiver stalls
    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg && !m_ready |=> skid_full_reg && !s_ready)
        else $error("skid register drained without a transfer");

    // outside points carry the unit factor
    a_outside_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_in_reg |-> m_df_reg == ONE_OUT)
        else $error("outside point with factor other than 1.0");

    // factor never exceeds 1.0
    a_factor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_df_reg <= ONE_OUT)
        else $error("density factor above 1.0");
`endif

endmodule

// ===== design/pcdf_trig.sv =====
// Pipelined |sin| or |cos| of the angle pi*num/(2*span).
// Restoring divider, one quotient bit per stage, then a Horner sine pipeline.
// Depends on pcdf_pkg.
`timescale 1ns / 1ps

module pcdf_trig import pcdf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int TRIG_BITS = TRIG_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [NUM_W-1:0]     num,
    input  logic [SPAN_W-1:0]    span,
    input  logic                 use_cos,
    output logic [FRAC_BITS:0]   mag
);

    localparam int NW = NUM_W + TRIG_BITS + 1;
    localparam int DW = SPAN_W + 2;
    localparam logic [FRAC_BITS:0] ONE_F = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [TRIG_BITS-1:0] QUARTER = TRIG_BITS'(1) << (TRIG_BITS - 2);

    // divider stages
    logic [NW-1:0]        dn_reg [NW];
    logic [DW-1:0]        dr_reg [NW];
    logic [DW-1:0]        dd_reg [NW];
    logic [TRIG_BITS-1:0] dq_reg [NW];
    logic                 dc_reg [NW];

    logic [NW-1:0]        n_in [NW];
    logic [DW-1:0]        r_in [NW];
    logic [DW-1:0]        d_in [NW];
    logic [TRIG_BITS-1:0] q_in [NW];
    logic                 c_in [NW];

    logic [NW-1:0]        n_next [NW];
    logic [DW-1:0]        r_next [NW];
    logic [TRIG_BITS-1:0] q_next [NW];

    // feed the first step with the rounded numerator and 4*span
    always_comb begin
        n_in[0] = NW'({num, {TRIG_BITS{1'b0}}}) + NW'({span, 1'b0});
        r_in[0] = '0;
        d_in[0] = {span, 2'b00};
        q_in[0] = '0;
        c_in[0] = use_cos;
        for (int k = 1; k < NW; k++) begin
            n_in[k] = dn_reg[k-1];
            r_in[k] = dr_reg[k-1];
            d_in[k] = dd_reg[k-1];
            q_in[k] = dq_reg[k-1];
            c_in[k] = dc_reg[k-1];
        end
    end

    // one restoring step per stage
    always_comb begin
        logic [DW:0] trial;
        trial = '0;
        for (int k = 0; k < NW; k++) begin
            trial = {r_in[k], n_in[k][NW-1]};
            n_next[k] = {n_in[k][NW-2:0], 1'b0};
            if (trial >= {1'b0, d_in[k]}) begin
                r_next[k] = DW'(trial - {1'b0, d_in[k]});
                q_next[k] = {q_in[k][TRIG_BITS-2:0], 1'b1};
            end else begin
                r_next[k] = DW'(trial);
                q_next[k] = {q_in[k][TRIG_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NW; k++) begin
                dn_reg[k] <= n_next[k];
                dr_reg[k] <= r_next[k];
                dd_reg[k] <= d_in[k];
                dq_reg[k] <= q_next[k];
                dc_reg[k] <= c_in[k];
            end
        end
    end

    // fold the phase onto the quarter wave
    logic [TRIG_BITS-1:0] phase;
    logic [29:0]          x_raw;
    logic [30:0]          x_fold;

    always_comb begin
        phase = dc_reg[NW-1] ? dq_reg[NW-1] + QUARTER : dq_reg[NW-1];
        x_raw = {phase[TRIG_BITS-3:0], {(32 - TRIG_BITS){1'b0}}};
        if (phase[TRIG_BITS-2]) begin
            x_fold = (31'd1 << 30) - {1'b0, x_raw};
        end else begin
            x_fold = {1'b0, x_raw};
        end
    end

    // sine pipeline
    logic [30:0] sx_reg;
    logic [30:0] hx_reg  [6];
    logic [30:0] hx2_reg [6];
    logic [31:0] ht_reg  [6];
    logic [FRAC_BITS:0] mag_reg;

    logic [61:0] sq_prod;
    logic [62:0] h_prod [6];
    logic [62:0] r_prod;
    logic [32:0] r_q30;
    logic [33:0] r_round;
    logic [33:0] r_scaled;

    always_comb begin
        sq_prod = 62'(sx_reg) * 62'(sx_reg);
        h_prod[0] = '0;
        for (int i = 1; i < 6; i++) begin
            h_prod[i] = 63'(hx2_reg[i-1]) * 63'(ht_reg[i-1]);
        end
        r_prod   = 63'(hx_reg[5]) * 63'(ht_reg[5]);
        r_q30    = r_prod[62:30];
        r_round  = 34'(r_q30) + (34'd1 << (29 - FRAC_BITS));
        r_scaled = r_round >> (30 - FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg     <= x_fold;
            hx_reg[0]  <= sx_reg;
            hx2_reg[0] <= sq_prod[60:30];
            ht_reg[0]  <= SIN_COEF[0];
            for (int i = 1; i < 6; i++) begin
                hx_reg[i]  <= hx_reg[i-1];
                hx2_reg[i] <= hx2_reg[i-1];
                ht_reg[i]  <= SIN_COEF[i] - h_prod[i][61:30];
            end
            if (r_scaled > 34'(ONE_F)) begin
                mag_reg <= ONE_F;
            end else begin
                mag_reg <= r_scaled[FRAC_BITS:0];
            end
        end
    end

    assign mag = mag_reg;

endmodule

// ===== bench/plasma_cavity_depletion_factor_chk.sv =====
// Checker for the plasma cavity depletion factor block: watches both channels,
// predicts each result in fixed point and compares it. Uses pcdf_pkg.
`timescale 1ns / 1ps

module plasma_cavity_depletion_factor_chk import pcdf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic signed [24:0]    s_altitude,
    input  logic [22:0]           s_inv_latitude,
    input  logic [20:0]           s_local_time,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [16:0]           m_density_factor,
    input  logic                  m_inside_res,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    output int                    fail_count,
    output int                    pending,
    output int                    inside_seen
);

    typedef struct packed {
        logic [16:0] factor;
        logic        in_cavity;
    } factor_t;

    factor_t factor_q[$];

    // local copy of the cavity registers
    longint c_ilat_c, c_ilat_hw, c_mlt_c, c_mlt_hw, c_top, c_bot, c_depth, c_en;

    localparam longint ONE = 65536;

    function automatic longint qmul(longint a, longint b);
        return (a * b + 32768) >>> 16;
    endfunction

    // magnitude of sine for a 16-bit phase in turns, Q.16
    function automatic longint sine_mag(longint phase);
        longint p, quad, x, x2, t, r;
        p = phase & 16'hFFFF;
        quad = (p >> 14) & 3;
        x = (p & 14'h3FFF) << 16;
        if (quad[0])
            x = (longint'(1) << 30) - x;
        x2 = (x * x) >> 30;
        t = SIN_COEF[0];
        for (int i = 1; i < 6; i++)
            t = longint'(SIN_COEF[i]) - ((x2 * t) >> 30);
        r = (x * t) >> 30;
        r = (r + (longint'(1) << 13)) >> 14;
        return (r > ONE) ? ONE : r;
    endfunction

    function automatic longint cosine_mag(longint phase);
        return sine_mag(phase + (1 << 14));
    endfunction

    function automatic longint turn_phase(longint num, longint span);
        longint den;
        if (span == 0)
            return 0;
        den = 4 * span;
        return ((num << 16) + den / 2) / den;
    endfunction

    function automatic factor_t predict_factor(longint h, longint ilat, longint mlt);
        factor_t r;
        longint dlat, dmlt, mmin, mmax, hf, s, base, sx, cy, sy, bowl, g, res, pl, pm;
        r.factor = 17'd65536;
        r.in_cavity = 1'b0;
        if (c_en == 0)
            return r;
        dlat = ilat - c_ilat_c;
        if (dlat > c_ilat_hw || -dlat > c_ilat_hw)
            return r;
        if (c_top < h)
            return r;
        mmin = c_mlt_c - c_mlt_hw;
        mmax = c_mlt_c + c_mlt_hw;
        if (mmin < 0 && mmax < mlt)
            mlt -= DAY_Q16;
        if (mmax > DAY_Q16 && mmin > mlt)
            mlt += DAY_Q16;
        if (mlt < mmin || mmax < mlt)
            return r;
        if (h < c_bot)
            hf = cosine_mag(turn_phase(h < 0 ? -h : h, c_bot != 0 ? c_bot : 1));
        else if (c_top <= c_bot)
            hf = sine_mag(0);
        else
            hf = sine_mag(turn_phase(h - c_bot, c_top - c_bot));
        s = (c_depth > ONE) ? ONE : c_depth;
        base = qmul(ONE - s, qmul(hf, hf)) + s;
        dmlt = mlt - c_mlt_c;
        pl = turn_phase(dlat < 0 ? -dlat : dlat, c_ilat_hw);
        pm = turn_phase(dmlt < 0 ? -dmlt : dmlt, c_mlt_hw);
        sx = sine_mag(pl);
        cy = cosine_mag(pm);
        sy = sine_mag(pm);
        bowl = qmul(qmul(sx, sx), qmul(cy, cy)) + qmul(sy, sy);
        if (bowl > ONE)
            bowl = ONE;
        g = qmul(ONE - base, bowl) + base;
        res = qmul(g, g);
        if (res > ONE)
            res = ONE;
        r.factor = res[16:0];
        r.in_cavity = 1'b1;
        return r;
    endfunction

    assign pending = factor_q.size();

    always @(posedge aclk) begin
        factor_t want;
        if (!aresetn) begin
            c_ilat_c = 0; c_ilat_hw = 65536; c_mlt_c = 0; c_mlt_hw = 65536;
            c_top = 0; c_bot = 1; c_depth = 65536; c_en = 0;
            factor_q.delete();
            fail_count = 0;
            inside_seen = 0;
        end else begin
            // track register writes
            if (cfg_we) begin
                case (cfg_addr)
                    REG_ILAT_CENTER:    c_ilat_c  = cfg_wdata[22:0];
                    REG_ILAT_HALFWIDTH: c_ilat_hw = cfg_wdata[22:0];
                    REG_MLT_CENTER:     c_mlt_c   = cfg_wdata[20:0];
                    REG_MLT_HALFWIDTH:  c_mlt_hw  = cfg_wdata[20:0];
                    REG_TOP_HEIGHT:     c_top     = cfg_wdata[23:0];
                    REG_BOTTOM_HEIGHT:  c_bot     = cfg_wdata[23:0];
                    REG_DEPTH_SCALE:    c_depth   = cfg_wdata[16:0];
                    REG_CAVITY_ENABLED: c_en      = cfg_wdata[0];
                    default: ;
                endcase
            end
            // predict each accepted request
            if (s_valid && s_ready)
                factor_q.push_back(predict_factor(longint'(s_altitude),
                    longint'(s_inv_latitude), longint'(s_local_time)));
            // compare each accepted result
            if (m_valid && m_ready) begin
                if (factor_q.size() == 0) begin
                    $error("unexpected result factor=%0d inside=%0b",
                           m_density_factor, m_inside_res);
                    fail_count++;
                end else begin
                    want = factor_q.pop_front();
                    if (want.in_cavity) inside_seen++;
                    if (m_density_factor !== want.factor) begin
                        $error("density_factor expected %0d actual %0d",
                               want.factor, m_density_factor);
                        fail_count++;
                    end
                    if (m_inside_res !== want.in_cavity) begin
                        $error("inside_res expected %0b actual %0b",
                               want.in_cavity, m_inside_res);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/plasma_cavity_depletion_factor_tb.sv =====
// Testbench top for the plasma cavity depletion factor block: drives sample
// points and register settings, stalls both sides. Uses pcdf_pkg and the checker.
`timescale 1ns / 1ps

module plasma_cavity_depletion_factor_tb import pcdf_pkg::*;;

    localparam int LATENCY  = 42 + TRIG_BITS_DEF;
    localparam int IDLE_LIM = 20000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic signed [24:0]    s_altitude = '0;
    logic [22:0]           s_inv_latitude = '0;
    logic [20:0]           s_local_time = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [16:0]           m_density_factor;
    logic                  m_inside_res;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    int fail_count, pending, inside_seen;
    int sent = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    bit steady = 1'b0;

    // cavity window currently programmed, for aiming random points
    int lat_c, lat_hw, mlt_c, mlt_hw, top_h, bot_h;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    plasma_cavity_depletion_factor DUT (.*);

    plasma_cavity_depletion_factor_chk u_chk (.*);

    // receiver: random stalls, a long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= !hold_off && (steady || $urandom_range(99) >= 19);
    end

    // watchdog on cycles with no request or result accepted
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIM) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // caller drops cfg_we after the last write of a burst
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val[CFG_W-1:0];
        @(posedge aclk);
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    task automatic program_cavity(input int lc, input int lhw, input int mc, input int mhw,
                                  input int top, input int bot, input int dep, input int en);
        drain();
        write_reg(REG_ILAT_CENTER, lc);
        write_reg(REG_ILAT_HALFWIDTH, lhw);
        write_reg(REG_MLT_CENTER, mc);
        write_reg(REG_MLT_HALFWIDTH, mhw);
        write_reg(REG_TOP_HEIGHT, top);
        write_reg(REG_BOTTOM_HEIGHT, bot);
        write_reg(REG_DEPTH_SCALE, dep);
        write_reg(REG_CAVITY_ENABLED, en);
        cfg_we <= 1'b0;
        lat_c = lc; lat_hw = lhw; mlt_c = mc; mlt_hw = mhw; top_h = top; bot_h = bot;
    endtask

    // offer one request and hold it until accepted
    task automatic send_point(input int alt, input int lat, input int mlt);
        if (!steady) begin
            while ($urandom_range(99) < 19) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_altitude <= alt[24:0];
        s_inv_latitude <= lat[22:0];
        s_local_time <= mlt[20:0];
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sent++;
    endtask

    function automatic int clip(input int v, input int lo, input int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // random point, mostly aimed into the programmed window
    task automatic send_random();
        int alt, lat, mlt;
        if ($urandom_range(99) < 75) begin
            alt = $urandom_range(4) == 0 ? -int'($urandom_range(top_h + 1))
                                         : int'($urandom_range(top_h + 2));
            lat = clip(lat_c - lat_hw + int'($urandom_range(2 * lat_hw + 2)), 0, 5898240);
            mlt = mlt_c - mlt_hw + int'($urandom_range(2 * mlt_hw + 2));
            mlt = ((mlt % DAY_Q16) + DAY_Q16) % DAY_Q16;
        end else begin
            alt = int'($urandom_range(32'h1FF_FFFF)) - 16777216;
            lat = $urandom_range(5898240);
            mlt = $urandom_range(1572863);
        end
        send_point(alt, lat, mlt);
    endtask

    task automatic random_phase(input int n);
        repeat (n) send_random();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: disabled cavity at reset values, field extremes
        send_point(-16777216, 0, 0);
        send_point(16777215, 5898240, 1572863);
        program_cavity(3932160, 655360, 1310720, 196608, 800000, 300000, 16384, 1);
        send_point(0, 3932160, 1310720);            // center, ground
        send_point(300000, 3932160, 1310720);       // at bottom height
        send_point(800000, 3932160, 1310720);       // at top height
        send_point(800001, 3932160, 1310720);       // just above top
        send_point(-150000, 3932160, 1310720);      // below ground
        send_point(550000, 3276800, 1310720);       // latitude edge
        send_point(550000, 3276799, 1310720);       // just outside latitude
        send_point(550000, 3932160, 1507328);       // local time edge
        send_point(550000, 3932160, 1507329);       // just outside local time
        // window wrapping below midnight, then above 24 h
        program_cavity(0, 5898240, 65536, 196608, 16777215, 1, 65537, 1);
        send_point(1000, 100, 1572863);
        send_point(1000, 5898240, 1441792);
        send_point(16777215, 0, 0);
        program_cavity(5898240, 1, 1540096, 1572864, 0, 16777215, 0, 1);
        send_point(-16777216, 5898240, 0);
        send_point(0, 5898239, 1572863);
        // top not above bottom, zero bottom height
        program_cavity(1000000, 300000, 500000, 1000, 5000, 5000, 30000, 1);
        send_point(5000, 1000000, 500000);
        program_cavity(1000000, 300000, 500000, 1000, 5000, 0, 30000, 1);
        send_point(0, 1000000, 500000);
        send_point(2500, 1100000, 500500);

        // random phases over several settings
        for (int ph = 0; ph < 8; ph++) begin
            program_cavity($urandom_range(5898240), $urandom_range(5898240) | 1,
                           $urandom_range(1572863), 1 + $urandom_range(1572863),
                           $urandom_range(1000000), 1 + $urandom_range(1000000),
                           $urandom_range(65536), $urandom_range(9) != 0);
            steady = (ph == 3);
            random_phase(140);
        end

        // long receiver hold-off while requests keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge aclk);
                hold_off = 1'b0;
            end
            random_phase(80);
        join
        // sender pause until everything is back, then the rest
        drain();
        random_phase(60);
        drain();

        $display("Covered %0d sample points, %0d inside the cavity, over a dozen settings.",
                 sent, inside_seen);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/pcdf_pkg.sv
design/pcdf_trig.sv
design/plasma_cavity_depletion_factor.sv
bench/plasma_cavity_depletion_factor_chk.sv
bench/plasma_cavity_depletion_factor_tb.sv
